// ===== rtl/lmtf_pkg.sv =====
package lmtf_pkg;

   localparam int NUM_COLUMNS = 56;
   localparam int COL_W       = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
   localparam int NUM_ROWS    = 8;
   localparam int ROW_BITS_W  = 56;

   typedef enum logic [1:0] {
      KIND_FILL = 2'd0,
      KIND_DRAW = 2'd1,
      KIND_SCAN = 2'd2,
      KIND_NONE = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      OP_CLEAR   = 2'd0,
      OP_OR      = 2'd1,
      OP_XOR     = 2'd2,
      OP_REPLACE = 2'd3
   } draw_op_type;

   typedef enum logic {
      DRAW_IDLE = 1'b0,
      DRAW_RUN  = 1'b1
   } draw_state_type;

   typedef struct packed {
      logic             en;
      logic [COL_W-1:0] col;
      logic [7:0]       data;
   } col_wr_type;

   typedef struct packed {
      logic       fill_en;
      logic [7:0] fill_value;
      col_wr_type wr;
   } store_cmd_type;

   typedef logic [7:0] font_entry_type [8];

   // width, then up to seven column patterns, bit 0 = top row
   localparam font_entry_type FONT_ROM [64] = '{
      '{8'd4, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
      '{8'd5, 8'd0, 8'd0, 8'd95, 8'd0, 8'd0, 8'd0, 8'd0},
      '{8'd5, 8'd0, 8'd7, 8'd0, 8'd7, 8'd0, 8'd0, 8'd0},
      '{8'd5, 8'd20, 8'd127, 8'd20, 8'd127, 8'd20, 8'd0, 8'd0},
      '{8'd5, 8'd4, 8'd42, 8'd107, 8'd42, 8'd16, 8'd0, 8'd0},
      '{8'd5, 8'd35, 8'd19, 8'd8, 8'd100, 8'd98, 8'd0, 8'd0},
      '{8'd5, 8'd54, 8'd73, 8'd85, 8'd34, 8'd80, 8'd0, 8'd0},
      '{8'd4, 8'd0, 8'd5, 8'd3, 8'd0, 8'd0, 8'd0, 8'd0},
      '{8'd5, 8'd0, 8'd28, 8'd34, 8'd65, 8'd0, 8'd0, 8'd0},
      '{8'd5, 8'd0, 8'd65, 8'd34, 8'd28, 8'd0, 8'd0, 8'd0},
      '{8'd5, 8'd20, 8'd8, 8'd62, 8'd8, 8'd20, 8'd0, 8'd0},
      '{8'd5, 8'd8, 8'd8, 8'd62, 8'd8, 8'd8, 8'd0, 8'd0},
      '{8'd4, 8'd0, 8'd80, 8'd48, 8'd0, 8'd0, 8'd0, 8'd0},
      '{8'd5, 8'd8, 8'd8, 8'd8, 8'd8, 8'd8, 8'd0, 8'd0},
      '{8'd4, 8'd0, 8'd96, 8'd96, 8'd0, 8'd0, 8'd0, 8'd0},
      '{8'd5, 8'd16, 8'd8, 8'd4, 8'd2, 8'd1, 8'd0, 8'd0},
      '{8'd5, 8'd62, 8'd65, 8'd65, 8'd65, 8'd62, 8'd0, 8'd0},
      '{8'd3, 8'd66, 8'd127, 8'd64, 8'd0, 8'd0, 8'd0, 8'd0},
      '{8'd5, 8'd66, 8'd97, 8'd81, 8'd73, 8'd70, 8'd0, 8'd0},
      '{8'd5, 8'd34, 8'd65, 8'd73, 8'd73, 8'd54, 8'd0, 8'd0},
      '{8'd5, 8'd24, 8'd20, 8'd18, 8'd127, 8'd16, 8'd0, 8'd0},
      '{8'd5, 8'd39, 8'd69, 8'd69, 8'd69, 8'd57, 8'd0, 8'd0},
      '{8'd5, 8'd60, 8'd74, 8'd73, 8'd73, 8'd48, 8'd0, 8'd0},
      '{8'd5, 8'd1, 8'd113, 8'd9, 8'd5, 8'd3, 8'd0, 8'd0},
      '{8'd5, 8'd54, 8'd73, 8'd73, 8'd73, 8'd54, 8'd0, 8'd0},
      '{8'd5, 8'd6, 8'd73, 8'd73, 8'd41, 8'd30, 8'd0, 8'd0},
      '{8'd5, 8'd54, 8'd54, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
      '{8'd5, 8'd86, 8'd54, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
      '{8'd5, 8'd8, 8'd20, 8'd34, 8'd65, 8'd0, 8'd0, 8'd0},
      '{8'd5, 8'd20, 8'd20, 8'd20, 8'd20, 8'd20, 8'd0, 8'd0},
      '{8'd5, 8'd65, 8'd34, 8'd20, 8'd8, 8'd0, 8'd0, 8'd0},
      '{8'd5, 8'd2, 8'd1, 8'd81, 8'd9, 8'd6, 8'd0, 8'd0},
      '{8'd5, 8'd62, 8'd65, 8'd93, 8'd85, 8'd30, 8'd0, 8'd0},
      '{8'd5, 8'd126, 8'd17, 8'd17, 8'd17, 8'd126, 8'd0, 8'd0},
      '{8'd5, 8'd127, 8'd73, 8'd73, 8'd73, 8'd54, 8'd0, 8'd0},
      '{8'd5, 8'd62, 8'd65, 8'd65, 8'd65, 8'd34, 8'd0, 8'd0},
      '{8'd5, 8'd127, 8'd65, 8'd65, 8'd34, 8'd28, 8'd0, 8'd0},
      '{8'd5, 8'd127, 8'd73, 8'd73, 8'd73, 8'd65, 8'd0, 8'd0},
      '{8'd5, 8'd127, 8'd9, 8'd9, 8'd9, 8'd1, 8'd0, 8'd0},
      '{8'd5, 8'd62, 8'd65, 8'd73, 8'd73, 8'd122, 8'd0, 8'd0},
      '{8'd5, 8'd127, 8'd8, 8'd8, 8'd8, 8'd127, 8'd0, 8'd0},
      '{8'd3, 8'd65, 8'd127, 8'd65, 8'd0, 8'd0, 8'd0, 8'd0},
      '{8'd5, 8'd32, 8'd64, 8'd65, 8'd63, 8'd1, 8'd0, 8'd0},
      '{8'd5, 8'd127, 8'd8, 8'd20, 8'd34, 8'd65, 8'd0, 8'd0},
      '{8'd5, 8'd127, 8'd64, 8'd64, 8'd64, 8'd64, 8'd0, 8'd0},
      '{8'd5, 8'd127, 8'd2, 8'd12, 8'd2, 8'd127, 8'd0, 8'd0},
      '{8'd5, 8'd127, 8'd4, 8'd8, 8'd16, 8'd127, 8'd0, 8'd0},
      '{8'd5, 8'd62, 8'd65, 8'd65, 8'd65, 8'd62, 8'd0, 8'd0},
      '{8'd5, 8'd127, 8'd9, 8'd9, 8'd9, 8'd6, 8'd0, 8'd0},
      '{8'd5, 8'd62, 8'd65, 8'd81, 8'd33, 8'd94, 8'd0, 8'd0},
      '{8'd5, 8'd127, 8'd9, 8'd25, 8'd41, 8'd70, 8'd0, 8'd0},
      '{8'd5, 8'd70, 8'd73, 8'd73, 8'd73, 8'd49, 8'd0, 8'd0},
      '{8'd5, 8'd1, 8'd1, 8'd127, 8'd1, 8'd1, 8'd0, 8'd0},
      '{8'd5, 8'd63, 8'd64, 8'd64, 8'd64, 8'd63, 8'd0, 8'd0},
      '{8'd5, 8'd31, 8'd32, 8'd64, 8'd32, 8'd31, 8'd0, 8'd0},
      '{8'd5, 8'd63, 8'd64, 8'd48, 8'd64, 8'd63, 8'd0, 8'd0},
      '{8'd5, 8'd99, 8'd20, 8'd8, 8'd20, 8'd99, 8'd0, 8'd0},
      '{8'd5, 8'd7, 8'd8, 8'd112, 8'd8, 8'd7, 8'd0, 8'd0},
      '{8'd5, 8'd97, 8'd81, 8'd73, 8'd69, 8'd67, 8'd0, 8'd0},
      '{8'd2, 8'd127, 8'd127, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
      '{8'd6, 8'd124, 8'd126, 8'd27, 8'd27, 8'd126, 8'd124, 8'd0},
      '{8'd6, 8'd124, 8'd126, 8'd27, 8'd27, 8'd126, 8'd124, 8'd0},
      '{8'd7, 8'd127, 8'd127, 8'd6, 8'd12, 8'd24, 8'd63, 8'd127},
      '{8'd7, 8'd62, 8'd73, 8'd85, 8'd81, 8'd85, 8'd73, 8'd62}
   };

endpackage

// ===== rtl/led_matrix_text_framebuffer_scan_unit.sv =====
// LED dot-matrix text frame buffer with row scan, 8 rows by NUM_COLUMNS.
// Request channel (req_*): one beat per item. Fill writes req_fill_value to
// every column; draw combines font glyph req_glyph at req_column (or at the
// text cursor when req_continue_text) using req_draw_op, then moves the
// cursor on by glyph width plus char_spacing, saturating at +127; scan
// returns one row on the response channel (rsp_*).
// Timing: a draw walks the glyph one column a cycle through a single
// position/raster-op unit, so it holds req_ready low after acceptance until
// its last column is written. A scan response is registered and appears the
// cycle after the request beat.
// Stall: the response register holds until rsp_ready; while it is full and
// not being taken, req_ready is low, so no beat is ever dropped.
// CSR channel (csr_*): writes char_spacing (reset value 1); always ready,
// write only while no item is in flight.
// Reset: synchronous; clears the frame store, scan row, cursor and the
// response valid flag.
module led_matrix_text_framebuffer_scan_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [2:0]            csr_wdata,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_kind,
   input  logic [7:0]            req_fill_value,
   input  logic [5:0]            req_glyph,
   input  logic signed [7:0]     req_column,
   input  logic                  req_continue_text,
   input  logic [1:0]            req_draw_op,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [2:0]            rsp_row,
   output logic [55:0]           rsp_row_bits,
   output logic                  rsp_frame_done
);

   localparam int WIDE_W = (lmtf_pkg::NUM_COLUMNS > lmtf_pkg::ROW_BITS_W) ?
                           lmtf_pkg::NUM_COLUMNS : lmtf_pkg::ROW_BITS_W;

   logic [2:0]        spacing_ff,   spacing_in;
   logic [2:0]        scan_row_ff,  scan_row_in;
   logic signed [7:0] cursor_ff,    cursor_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [2:0]        rsp_row_ff,   rsp_row_in;
   logic [55:0]       rsp_bits_ff,  rsp_bits_in;

   logic                              busy;
   logic                              req_beat;
   logic                              draw_start;
   logic [lmtf_pkg::COL_W-1:0]        rd_col;
   logic [7:0]                        rd_data;
   logic [lmtf_pkg::NUM_COLUMNS-1:0]  scan_bits;
   logic [WIDE_W-1:0]                 scan_wide;
   lmtf_pkg::col_wr_type              wr;
   lmtf_pkg::store_cmd_type           cmd;
   logic                              cursor_we;
   logic signed [7:0]                 cursor_value;

   assign csr_ready = 1'b1;
   assign req_ready = !busy && (!rsp_valid_ff || rsp_ready);
   assign req_beat  = req_valid && req_ready;
   assign draw_start = req_beat && (req_kind == lmtf_pkg::KIND_DRAW);

   always_comb begin
      cmd.fill_en    = req_beat && (req_kind == lmtf_pkg::KIND_FILL);
      cmd.fill_value = req_fill_value;
      cmd.wr         = wr;
   end

   lmtf_frame_store u_store (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .rd_col    (rd_col),
      .rd_data   (rd_data),
      .scan_row  (scan_row_ff),
      .scan_bits (scan_bits)
   );

   lmtf_draw_unit u_draw (
      .clock        (clock),
      .reset        (reset),
      .start        (draw_start),
      .glyph        (req_glyph),
      .start_col    (req_continue_text ? cursor_ff : req_column),
      .draw_op      (req_draw_op),
      .char_spacing (spacing_ff),
      .busy         (busy),
      .rd_col       (rd_col),
      .rd_data      (rd_data),
      .wr           (wr),
      .cursor_we    (cursor_we),
      .cursor_value (cursor_value)
   );

   assign scan_wide = WIDE_W'(scan_bits);

   always_comb begin
      spacing_in   = csr_valid ? csr_wdata : spacing_ff;
      cursor_in    = cursor_we ? cursor_value : cursor_ff;
      scan_row_in  = scan_row_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_row_in   = rsp_row_ff;
      rsp_bits_in  = rsp_bits_ff;
      if (req_beat && req_kind == lmtf_pkg::KIND_SCAN) begin
         rsp_valid_in = 1'b1;
         rsp_row_in   = scan_row_ff;
         rsp_bits_in  = scan_wide[55:0];
         scan_row_in  = 3'(scan_row_ff + 3'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spacing_ff   <= 3'd1;
         scan_row_ff  <= 3'd0;
         cursor_ff    <= 8'sd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         spacing_ff   <= spacing_in;
         scan_row_ff  <= scan_row_in;
         cursor_ff    <= cursor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_row_ff  <= rsp_row_in;
      rsp_bits_ff <= rsp_bits_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_row        = rsp_row_ff;
   assign rsp_row_bits   = rsp_bits_ff;
   assign rsp_frame_done = (rsp_row_ff == 3'd7);

endmodule

// ===== rtl/lmtf_frame_store.sv =====
module lmtf_frame_store (
   input  logic                                 clock,
   input  logic                                 reset,
   input  lmtf_pkg::store_cmd_type              cmd,
   input  logic [lmtf_pkg::COL_W-1:0]           rd_col,
   output logic [7:0]                           rd_data,
   input  logic [2:0]                           scan_row,
   output logic [lmtf_pkg::NUM_COLUMNS-1:0]     scan_bits
);

   // row-major: one register per matrix row, one bit per column
   logic [lmtf_pkg::NUM_COLUMNS-1:0] row_ff [lmtf_pkg::NUM_ROWS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < lmtf_pkg::NUM_ROWS; r++) begin
            row_ff[r] <= '0;
         end
      end else if (cmd.fill_en) begin
         for (int r = 0; r < lmtf_pkg::NUM_ROWS; r++) begin
            row_ff[r] <= {lmtf_pkg::NUM_COLUMNS{cmd.fill_value[r]}};
         end
      end else if (cmd.wr.en) begin
         for (int r = 0; r < lmtf_pkg::NUM_ROWS; r++) begin
            row_ff[r][cmd.wr.col] <= cmd.wr.data[r];
         end
      end
   end

   always_comb begin
      for (int r = 0; r < lmtf_pkg::NUM_ROWS; r++) begin
         rd_data[r] = row_ff[r][rd_col];
      end
   end

   assign scan_bits = row_ff[scan_row];

endmodule

// ===== rtl/lmtf_draw_unit.sv =====
module lmtf_draw_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [5:0]                    glyph,
   input  logic signed [7:0]             start_col,
   input  logic [1:0]                    draw_op,
   input  logic [2:0]                    char_spacing,
   output logic                          busy,
   output logic [lmtf_pkg::COL_W-1:0]    rd_col,
   input  logic [7:0]                    rd_data,
   output lmtf_pkg::col_wr_type          wr,
   output logic                          cursor_we,
   output logic signed [7:0]             cursor_value
);

   lmtf_pkg::draw_state_type state_ff, state_in;
   logic [5:0]        glyph_ff,  glyph_in;
   logic signed [7:0] start_ff,  start_in;
   logic [1:0]        op_ff,     op_in;
   logic [2:0]        idx_ff,    idx_in;

   logic [2:0] width;
   logic [7:0] pat;
   logic [8:0] pos;
   logic       in_range;
   logic       last;
   logic [9:0] next_pos;
   logic [7:0] new_col;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lmtf_pkg::DRAW_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      glyph_ff <= glyph_in;
      start_ff <= start_in;
      op_ff    <= op_in;
      idx_ff   <= idx_in;
   end

   // shared column step: position add, range check, raster op
   always_comb begin
      width    = lmtf_pkg::FONT_ROM[glyph_ff][0][2:0];
      pat      = lmtf_pkg::FONT_ROM[glyph_ff][3'(idx_ff + 3'd1)];
      pos      = {start_ff[7], start_ff} + {6'b0, idx_ff};
      in_range = !pos[8] && (pos < 9'(lmtf_pkg::NUM_COLUMNS));
      rd_col   = pos[lmtf_pkg::COL_W-1:0];
      last     = (idx_ff == 3'(width - 3'd1));
      next_pos = {{2{start_ff[7]}}, start_ff} + {7'b0, width} + {7'b0, char_spacing};

      case (lmtf_pkg::draw_op_type'(op_ff))
         lmtf_pkg::OP_CLEAR: new_col = rd_data & ~pat;
         lmtf_pkg::OP_OR:    new_col = rd_data | pat;
         lmtf_pkg::OP_XOR:   new_col = rd_data ^ pat;
         default:            new_col = pat;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      glyph_in     = glyph_ff;
      start_in     = start_ff;
      op_in        = op_ff;
      idx_in       = idx_ff;
      busy         = 1'b0;
      wr.en        = 1'b0;
      wr.col       = rd_col;
      wr.data      = new_col;
      cursor_we    = 1'b0;
      cursor_value = (!next_pos[9] && next_pos[8:7] != 2'b00) ? 8'sd127
                                                             : next_pos[7:0];

      case (state_ff)
         lmtf_pkg::DRAW_IDLE: begin
            if (start) begin
               glyph_in = glyph;
               start_in = start_col;
               op_in    = draw_op;
               idx_in   = 3'd0;
               state_in = lmtf_pkg::DRAW_RUN;
            end
         end
         lmtf_pkg::DRAW_RUN: begin
            busy   = 1'b1;
            wr.en  = in_range;
            idx_in = 3'(idx_ff + 3'd1);
            if (last) begin
               cursor_we = 1'b1;
               state_in  = lmtf_pkg::DRAW_IDLE;
            end
         end
         default: begin
            state_in = lmtf_pkg::DRAW_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/lmtf_checker.sv =====
module lmtf_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic [1:0]        req_kind,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [2:0]        rsp_row,
   input logic [55:0]       rsp_row_bits,
   input logic              rsp_frame_done
);

   a_frame_done : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_frame_done == (rsp_row == 3'd7)))
      else $error("frame_done does not match last row");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_row)
                                   && $stable(rsp_row_bits))
      else $error("stalled response beat changed");

   a_draw_busy : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_kind == lmtf_pkg::KIND_DRAW |=> !req_ready)
      else $error("request taken during glyph draw");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_scan_only : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !(req_valid && req_ready && req_kind == lmtf_pkg::KIND_SCAN)
      |=> !rsp_valid)
      else $error("response beat without scan request");

endmodule

bind led_matrix_text_framebuffer_scan_unit lmtf_checker u_lmtf_checker (.*);
